// ===== design/dsr_pkg.sv =====
package dsr_pkg;

    // request kinds on the input channel
    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_STEP_LOW  = 2'd0,
        REG_STEP_HIGH = 2'd1,
        REG_TIMEOUT   = 2'd2
    } reg_idx_t;

    localparam int          APB_AW = 4;

    localparam logic [31:0] STEP_LOW_RST  = 32'd134546178;
    localparam logic [31:0] STEP_HIGH_RST = 32'd672731660;
    localparam logic [15:0] TIMEOUT_RST   = 16'd50;

    localparam logic signed [8:0] SPD_MAX = 9'sd255;
    localparam logic [15:0]       IDLE_SAT = 16'hFFFF;

    // pulse width endpoints in us
    localparam logic [11:0] US_MIN = 12'd500;
    localparam logic [11:0] US_MAX = 12'd2500;

    // floor(v*2000/510) as (v*SPAN_RECIP) >> SPAN_SHIFT, exact for v in 0..510
    localparam int          SPAN_SHIFT = 24;
    localparam logic [25:0] SPAN_RECIP = 26'd65793004;
    localparam int          Q_W        = 11;

    // floor(us*16383/20000) as (us*DUTY_RECIP) >> DUTY_SHIFT, exact for us up to 2500
    localparam int          DUTY_SHIFT = 32;
    localparam logic [31:0] DUTY_RECIP = 32'd3518222461;
    localparam int          DUTY_W     = 14;

    // duty range reachable from 500..2500 us
    localparam logic [DUTY_W-1:0] DUTY_LO = 14'd409;
    localparam logic [DUTY_W-1:0] DUTY_HI = 14'd2047;

    typedef struct packed {
        logic [31:0] step_low;
        logic [31:0] step_high;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [8:0] left;
        logic signed [8:0] right;
    } spd_pair_t;

    function automatic logic signed [8:0] sat_speed(input logic signed [15:0] v);
        logic signed [8:0] r;
        if (v > 16'sd255) begin
            r = SPD_MAX;
        end else if (v < -16'sd255) begin
            r = -SPD_MAX;
        end else begin
            r = 9'(v);
        end
        return r;
    endfunction

    // one slew step toward goal, step size picked by |cur|/32
    function automatic logic signed [8:0] ramp_step(
        input logic signed [8:0] cur,
        input logic signed [8:0] goal,
        input logic [31:0]       lo,
        input logic [31:0]       hi
    );
        logic [7:0]         mag;
        logic [2:0]         bkt;
        logic [31:0]        word;
        logic [7:0]         stp;
        logic signed [10:0] cur_x;
        logic signed [10:0] goal_x;
        logic signed [10:0] stp_x;
        logic signed [10:0] sum;
        logic signed [10:0] res;
        mag    = cur[8] ? 8'(-cur) : cur[7:0];
        bkt    = mag[7:5];
        word   = bkt[2] ? hi : lo;
        stp    = word[8*bkt[1:0] +: 8];
        cur_x  = 11'(cur);
        goal_x = 11'(goal);
        stp_x  = signed'(11'(stp));
        if (cur_x < goal_x) begin
            sum = cur_x + stp_x;
            res = (sum > goal_x) ? goal_x : sum;
        end else if (cur_x > goal_x) begin
            sum = cur_x - stp_x;
            res = (sum < goal_x) ? goal_x : sum;
        end else begin
            res = cur_x;
        end
        return 9'(res);
    endfunction

endpackage

// ===== design/dsr_ctrl.sv =====
module dsr_ctrl
    import dsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic signed [15:0] s_left_speed_cmd,
    input  logic signed [15:0] s_right_speed_cmd,
    output logic              spd_valid,
    input  logic              spd_ready,
    output spd_pair_t         spd
);

    logic              in_valid_reg,  in_valid_next;
    logic              in_type_reg;
    logic signed [15:0] in_left_reg;
    logic signed [15:0] in_right_reg;

    logic signed [8:0] goal_left_reg,   goal_left_next;
    logic signed [8:0] goal_right_reg,  goal_right_next;
    logic signed [8:0] speed_left_reg,  speed_left_next;
    logic signed [8:0] speed_right_reg, speed_right_next;
    logic signed [8:0] shown_left_reg,  shown_left_next;
    logic signed [8:0] shown_right_reg, shown_right_next;
    logic              shown_valid_reg, shown_valid_next;
    logic              active_reg,      active_next;
    logic [15:0]       idle_ticks_reg,  idle_ticks_next;

    logic              spd_valid_reg, spd_valid_next;
    spd_pair_t         spd_reg;

    logic              mid_free;
    logic              fire;
    logic              emit;
    logic [15:0]       idle_inc;
    logic              timed_out;
    logic signed [8:0] goal_l_eff;
    logic signed [8:0] goal_r_eff;
    logic signed [8:0] new_l;
    logic signed [8:0] new_r;
    logic              changed;

    assign mid_free = !spd_valid_reg || spd_ready;
    assign fire     = in_valid_reg && mid_free;
    assign s_ready  = !in_valid_reg || mid_free;

    assign idle_inc   = (idle_ticks_reg != IDLE_SAT) ? idle_ticks_reg + 16'd1 : idle_ticks_reg;
    assign timed_out  = idle_inc > cfg.timeout_ticks;
    assign goal_l_eff = timed_out ? 9'sd0 : goal_left_reg;
    assign goal_r_eff = timed_out ? 9'sd0 : goal_right_reg;
    assign new_l      = ramp_step(speed_left_reg,  goal_l_eff, cfg.step_low, cfg.step_high);
    assign new_r      = ramp_step(speed_right_reg, goal_r_eff, cfg.step_low, cfg.step_high);
    assign changed    = !shown_valid_reg || (new_l != shown_left_reg)
                        || (new_r != shown_right_reg);
    assign emit       = fire && (in_type_reg == REQ_TICK) && active_reg && changed;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign spd_valid_next = mid_free ? emit : spd_valid_reg;

    always_comb begin
        goal_left_next   = goal_left_reg;
        goal_right_next  = goal_right_reg;
        speed_left_next  = speed_left_reg;
        speed_right_next = speed_right_reg;
        shown_left_next  = shown_left_reg;
        shown_right_next = shown_right_reg;
        shown_valid_next = shown_valid_reg;
        active_next      = active_reg;
        idle_ticks_next  = idle_ticks_reg;
        if (fire) begin
            if (in_type_reg == REQ_CMD) begin
                goal_left_next  = sat_speed(in_left_reg);
                goal_right_next = sat_speed(in_right_reg);
                active_next     = 1'b1;
                idle_ticks_next = '0;
            end else if (active_reg) begin
                idle_ticks_next  = idle_inc;
                goal_left_next   = goal_l_eff;
                goal_right_next  = goal_r_eff;
                // stop only once both wheels were already at rest
                if (timed_out && speed_left_reg == 9'sd0 && speed_right_reg == 9'sd0) begin
                    active_next = 1'b0;
                end
                speed_left_next  = new_l;
                speed_right_next = new_r;
                if (changed) begin
                    shown_left_next  = new_l;
                    shown_right_next = new_r;
                    shown_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            spd_valid_reg   <= 1'b0;
            goal_left_reg   <= '0;
            goal_right_reg  <= '0;
            speed_left_reg  <= '0;
            speed_right_reg <= '0;
            shown_left_reg  <= '0;
            shown_right_reg <= '0;
            shown_valid_reg <= 1'b0;
            active_reg      <= 1'b0;
            idle_ticks_reg  <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            spd_valid_reg   <= spd_valid_next;
            goal_left_reg   <= goal_left_next;
            goal_right_reg  <= goal_right_next;
            speed_left_reg  <= speed_left_next;
            speed_right_reg <= speed_right_next;
            shown_left_reg  <= shown_left_next;
            shown_right_reg <= shown_right_next;
            shown_valid_reg <= shown_valid_next;
            active_reg      <= active_next;
            idle_ticks_reg  <= idle_ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg  <= s_req_type;
            in_left_reg  <= s_left_speed_cmd;
            in_right_reg <= s_right_speed_cmd;
        end
        if (emit) begin
            spd_reg.left  <= new_l;
            spd_reg.right <= new_r;
        end
    end

    assign spd_valid = spd_valid_reg;
    assign spd       = spd_reg;

endmodule

// ===== design/dsr_map.sv =====
module dsr_map
    import dsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              spd_valid,
    output logic              spd_ready,
    input  spd_pair_t         spd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DUTY_W-1:0] m_left_pin_duty,
    output logic [DUTY_W-1:0] m_right_pin_duty
);

    localparam int SPAN_PW = 9 + 26;
    localparam int DUTY_PW = 12 + 32;

    logic                  us_valid_reg, us_valid_next;
    logic [11:0]           us_lpin_reg;
    logic [11:0]           us_rpin_reg;
    logic                  m_valid_reg,  m_valid_next;
    logic [DUTY_W-1:0]     duty_l_reg;
    logic [DUTY_W-1:0]     duty_r_reg;

    logic                  us_free;
    logic                  out_free;
    logic [9:0]            off_l;
    logic [9:0]            off_r;
    logic [SPAN_PW-1:0]    span_l;
    logic [SPAN_PW-1:0]    span_r;
    logic [Q_W-1:0]        q_l;
    logic [Q_W-1:0]        q_r;
    logic [DUTY_PW-1:0]    prod_l;
    logic [DUTY_PW-1:0]    prod_r;

    assign out_free  = !m_valid_reg || m_ready;
    assign us_free   = !us_valid_reg || out_free;
    assign spd_ready = us_free;

    // stage 1: speed -> pulse width, speed offset to 0..510
    assign off_l  = 10'(spd.left)  + 10'd255;
    assign off_r  = 10'(spd.right) + 10'd255;
    assign span_l = SPAN_PW'(off_l[8:0]) * SPAN_PW'(SPAN_RECIP);
    assign span_r = SPAN_PW'(off_r[8:0]) * SPAN_PW'(SPAN_RECIP);
    assign q_l    = span_l[SPAN_SHIFT +: Q_W];
    assign q_r    = span_r[SPAN_SHIFT +: Q_W];

    // stage 2: pulse width -> duty
    assign prod_l = DUTY_PW'(us_lpin_reg) * DUTY_PW'(DUTY_RECIP);
    assign prod_r = DUTY_PW'(us_rpin_reg) * DUTY_PW'(DUTY_RECIP);

    assign us_valid_next = us_free  ? spd_valid    : us_valid_reg;
    assign m_valid_next  = out_free ? us_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            us_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            us_valid_reg <= us_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (spd_valid && us_free) begin
            // left pin follows right wheel, right pin is mirrored
            us_lpin_reg <= US_MIN + 12'(q_r);
            us_rpin_reg <= US_MAX - 12'(q_l);
        end
        if (us_valid_reg && out_free) begin
            duty_l_reg <= DUTY_W'(prod_l[DUTY_PW-1:DUTY_SHIFT]);
            duty_r_reg <= DUTY_W'(prod_r[DUTY_PW-1:DUTY_SHIFT]);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_pin_duty  = duty_l_reg;
    assign m_right_pin_duty = duty_r_reg;

endmodule

// ===== design/dual_servo_ramp_with_watchdog.sv =====
// dual servo speed ramp with command watchdog
//
// input channel (s_valid/s_ready): each request is either a speed command
// (s_req_type = 0, both speeds saturated to -255..255 and stored as targets)
// or a control tick (s_req_type = 1) that, while running, moves both current
// speeds one slew step toward their targets. commands never produce a result;
// a running tick produces one result (m_valid/m_ready) of two 14-bit servo duties
// whenever the speed pair differs from the last one sent, or on the first tick.
// configuration: APB-style port, step tables at 0x0 and 0x4, watchdog
// timeout in ticks at 0x8; pready is tied high, writes take effect at once.
// throughput: one request per cycle until a stalled receiver fills the pipeline.
// a tick passes the input register, the ramp and state update, the pulse width
// multiply and the duty multiply registers on its way to m_valid; the two
// reciprocal multipliers each have their own stage.
// a stalled receiver holds the result; the two inner stages and the input
// register keep absorbing requests until all are full, then s_ready drops.
// reset (aresetn low, synchronous) clears the pipeline, the watchdog, all
// speeds and targets, and loads the default step tables and timeout.
module dual_servo_ramp_with_watchdog
    import dsr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic signed [15:0] s_left_speed_cmd,
    input  logic signed [15:0] s_right_speed_cmd,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DUTY_W-1:0]  m_left_pin_duty,
    output logic [DUTY_W-1:0]  m_right_pin_duty,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t      cfg_reg;
    reg_idx_t  reg_idx;
    logic      cfg_wr;

    logic      spd_valid;
    logic      spd_ready;
    spd_pair_t spd;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes, unused addresses are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_low      <= STEP_LOW_RST;
            cfg_reg.step_high     <= STEP_HIGH_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_STEP_LOW:  cfg_reg.step_low      <= pwdata;
                REG_STEP_HIGH: cfg_reg.step_high     <= pwdata;
                REG_TIMEOUT:   cfg_reg.timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_STEP_LOW:  prdata = cfg_reg.step_low;
            REG_STEP_HIGH: prdata = cfg_reg.step_high;
            REG_TIMEOUT:   prdata = {16'd0, cfg_reg.timeout_ticks};
            default:       prdata = '0;
        endcase
    end

    // input register, watchdog and slew ramp
    dsr_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_left_speed_cmd  (s_left_speed_cmd),
        .s_right_speed_cmd (s_right_speed_cmd),
        .spd_valid         (spd_valid),
        .spd_ready         (spd_ready),
        .spd               (spd)
    );

    // speed pair to servo duties, ends in the result register
    dsr_map u_map (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .spd_valid        (spd_valid),
        .spd_ready        (spd_ready),
        .spd              (spd),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_pin_duty  (m_left_pin_duty),
        .m_right_pin_duty (m_right_pin_duty)
    );

endmodule

// ===== design/dsr_checker.sv =====
module dsr_checker
    import dsr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DUTY_W-1:0] m_left_pin_duty,
    input logic [DUTY_W-1:0] m_right_pin_duty
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // duties stay within the 500..2500 us window
    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_pin_duty >= DUTY_LO && m_left_pin_duty <= DUTY_HI
                     && m_right_pin_duty >= DUTY_LO && m_right_pin_duty <= DUTY_HI))
        else $error("servo duty out of range");

    // requests back up only behind a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("request side blocked without a stalled result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_left_pin_duty)
                                   && $stable(m_right_pin_duty)))
        else $error("stalled result changed");

endmodule

bind dual_servo_ramp_with_watchdog dsr_checker u_dsr_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import dsr_pkg::*;
();

    // ------------------------------------------------------------------
    // local constants for the duty prediction
    // ------------------------------------------------------------------
    localparam int DUTY_FULL   = 16383;
    localparam int FRAME_US    = 20000;
    localparam int US_SPAN     = 2000;
    localparam int IN_SPAN     = 510;
    localparam int BUCKET_W    = 32;
    localparam int STALL_LIMIT = 3000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int END_WAIT    = 20;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } servo_req_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
    } duty_pair_t;

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               s_valid           = 1'b0;
    logic               s_req_type        = REQ_CMD;
    logic signed [15:0] s_left_speed_cmd  = '0;
    logic signed [15:0] s_right_speed_cmd = '0;
    logic               m_ready           = 1'b0;
    logic               psel              = 1'b0;
    logic               penable           = 1'b0;
    logic               pwrite            = 1'b0;
    logic [APB_AW-1:0]  paddr             = '0;
    logic [31:0]        pwdata            = '0;

    logic               s_ready;
    logic               m_valid;
    logic [DUTY_W-1:0]  m_left_pin_duty;
    logic [DUTY_W-1:0]  m_right_pin_duty;
    logic [31:0]        prdata;
    logic               pready;

    always #1 aclk = ~aclk;

    dual_servo_ramp_with_watchdog uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_left_speed_cmd  (s_left_speed_cmd),
        .s_right_speed_cmd (s_right_speed_cmd),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_pin_duty   (m_left_pin_duty),
        .m_right_pin_duty  (m_right_pin_duty),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // ------------------------------------------------------------------
    // shared testbench state
    // ------------------------------------------------------------------
    servo_req_t pending_reqs[$];   // requests waiting for the driver
    duty_pair_t duty_expect[$];    // predicted duty pairs, oldest first

    int errors        = 0;
    int n_cmds        = 0;
    int n_live_ticks  = 0;
    int n_dead_ticks  = 0;
    int n_trips       = 0;
    int n_results     = 0;
    int n_settings    = 0;
    int hold_orders   = 0;         // bumped by the sequencer to order a long hold
    bit calm          = 1'b0;      // no idling on either side while set

    // shadow of the configuration registers
    logic [31:0] cfg_step_lo = STEP_LOW_RST;
    logic [31:0] cfg_step_hi = STEP_HIGH_RST;
    logic [15:0] cfg_timeout = TIMEOUT_RST;

    // shadow of the ramp state
    logic signed [8:0] goal_l  = '0;
    logic signed [8:0] goal_r  = '0;
    logic signed [8:0] spd_l   = '0;
    logic signed [8:0] spd_r   = '0;
    logic signed [8:0] shown_l = '0;
    logic signed [8:0] shown_r = '0;
    bit                shown_ok = 1'b0;
    bit                running  = 1'b0;
    logic [15:0]       idle_cnt = '0;

    // ------------------------------------------------------------------
    // duty predictor
    // ------------------------------------------------------------------

    // saturate a requested speed to the servo range
    function automatic logic signed [8:0] clip_speed(input logic signed [15:0] v);
        int x;
        x = v;
        if (x > int'(SPD_MAX)) x = int'(SPD_MAX);
        if (x < -int'(SPD_MAX)) x = -int'(SPD_MAX);
        return 9'(x);
    endfunction

    // step size from the table, bucket = |speed| / 32
    function automatic int slew_size(input int cur);
        int          mag;
        int          bkt;
        logic [31:0] word;
        mag  = (cur < 0) ? -cur : cur;
        bkt  = mag / BUCKET_W;
        if (bkt > 7) bkt = 7;
        word = (bkt < 4) ? cfg_step_lo : cfg_step_hi;
        return int'((word >> (8 * (bkt % 4))) & 32'hFF);
    endfunction

    // move one step toward the goal, never past it
    function automatic logic signed [8:0] slew(input logic signed [8:0] cur_s,
                                               input logic signed [8:0] goal_s);
        int cur;
        int goal;
        int stp;
        cur  = cur_s;
        goal = goal_s;
        stp  = slew_size(cur);
        if (cur < goal) begin
            cur = cur + stp;
            if (cur > goal) cur = goal;
        end else if (cur > goal) begin
            cur = cur - stp;
            if (cur < goal) cur = goal;
        end
        return 9'(cur);
    endfunction

    function automatic logic [DUTY_W-1:0] pw_to_duty(input int us);
        if (us < int'(US_MIN)) us = int'(US_MIN);
        if (us > int'(US_MAX)) us = int'(US_MAX);
        return DUTY_W'((us * DUTY_FULL) / FRAME_US);
    endfunction

    // update the shadow state for one accepted request, queue a duty pair if one is due
    task automatic predict_request(input logic kind,
                                   input logic signed [15:0] lcmd,
                                   input logic signed [15:0] rcmd);
        duty_pair_t d;
        int         ql;
        int         qr;
        if (kind == REQ_CMD) begin
            goal_l   = clip_speed(lcmd);
            goal_r   = clip_speed(rcmd);
            running  = 1'b1;
            idle_cnt = '0;
            n_cmds++;
        end else if (!running) begin
            n_dead_ticks++;
        end else begin
            n_live_ticks++;
            if (idle_cnt != IDLE_SAT) idle_cnt = idle_cnt + 16'd1;
            // watchdog: targets forced to zero, stop once both speeds are zero
            if (idle_cnt > cfg_timeout) begin
                n_trips++;
                goal_l = '0;
                goal_r = '0;
                if (spd_l == 0 && spd_r == 0) running = 1'b0;
            end
            spd_l = slew(spd_l, goal_l);
            spd_r = slew(spd_r, goal_r);
            if (!shown_ok || spd_l != shown_l || spd_r != shown_r) begin
                // left pin follows the right speed, right pin the mirrored left speed
                qr = ((int'(spd_r) + int'(SPD_MAX)) * US_SPAN) / IN_SPAN;
                ql = ((int'(spd_l) + int'(SPD_MAX)) * US_SPAN) / IN_SPAN;
                d.left_duty  = pw_to_duty(int'(US_MIN) + qr);
                d.right_duty = pw_to_duty(int'(US_MAX) - ql);
                duty_expect.push_back(d);
                shown_l  = spd_l;
                shown_r  = spd_r;
                shown_ok = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: feeds pending_reqs into the block, random gaps
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge aclk) begin : req_driver
        bit         fire;
        bit         nxt_valid;
        int         r;
        servo_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            fire = s_valid && s_ready;
            // payload still holds the accepted request at this edge
            if (fire) predict_request(s_req_type, s_left_speed_cmd, s_right_speed_cmd);
            if (!s_valid || fire) begin
                if (fire && !calm) begin
                    r = $urandom_range(0, 99);
                    if (r < 75)      gap_left = 0;
                    else if (r < 95) gap_left = $urandom_range(1, 3);
                    else             gap_left = $urandom_range(15, 60);
                end
                if (gap_left > 0 || pending_reqs.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    nxt_valid = 1'b0;
                end else begin
                    nxt       = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    s_req_type        <= nxt.kind;
                    s_left_speed_cmd  <= nxt.left;
                    s_right_speed_cmd <= nxt.right;
                end
                s_valid <= nxt_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver back-pressure
    // ------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    always @(posedge aclk) begin : duty_monitor
        duty_pair_t want;
        bit         rdy;
        int         r;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (duty_expect.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got left %0d right %0d",
                         $time, m_left_pin_duty, m_right_pin_duty);
            end else begin
                want = duty_expect.pop_front();
                if (m_left_pin_duty !== want.left_duty) begin
                    errors++;
                    $display("%0t: left_pin_duty expected %0d got %0d",
                             $time, want.left_duty, m_left_pin_duty);
                end
                if (m_right_pin_duty !== want.right_duty) begin
                    errors++;
                    $display("%0t: right_pin_duty expected %0d got %0d",
                             $time, want.right_duty, m_right_pin_duty);
                end
            end
        end
        // a long hold ordered by the sequencer, counted here
        if (hold_seen != hold_orders) begin
            hold_seen = hold_orders;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (calm) begin
            rdy = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                rdy = 1'b1;
            end else if (r < 97) begin
                stall_left = $urandom_range(0, 2);
                rdy = 1'b0;
            end else begin
                stall_left = $urandom_range(20, 80);
                rdy = 1'b0;
            end
        end
        m_ready <= rdy;
    end

    // ------------------------------------------------------------------
    // watchdog on forward progress
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin : progress_watch
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, duty_expect.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequencer helpers
    // ------------------------------------------------------------------

    // apb write: setup cycle then access cycle, shadow updated once it lands
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP_LOW:  cfg_step_lo = val;
            REG_STEP_HIGH: cfg_step_hi = val;
            REG_TIMEOUT:   cfg_timeout = val[15:0];
            default: ;
        endcase
    endtask

    task automatic push_req(input logic kind, input int l, input int r);
        servo_req_t q;
        q.kind  = kind;
        q.left  = 16'(l);
        q.right = 16'(r);
        pending_reqs.push_back(q);
    endtask

    // wait until everything sent and every result back, then let the pipe empty
    task automatic settle();
        while (pending_reqs.size() != 0 || s_valid || duty_expect.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // speed request: mostly near the servo range, some full 16-bit, some corners
    function automatic int rand_speed();
        int r;
        int pick;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 600) - 300;
        if (r < 85) return int'($signed(16'($urandom())));
        pick = $urandom_range(0, 6);
        case (pick)
            0: return 32767;
            1: return -32768;
            2: return 255;
            3: return -255;
            4: return 256;
            5: return -256;
            default: return 0;
        endcase
    endfunction

    // one burst: mostly a command followed by a run of ticks
    task automatic push_burst(input int max_ticks);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            push_req(REQ_CMD, rand_speed(), rand_speed());
            n = $urandom_range(1, max_ticks);
            repeat (n) push_req(REQ_TICK, rand_speed(), rand_speed());
        end else if (r < 90) begin
            // commands back to back, the last one wins
            n = $urandom_range(2, 3);
            repeat (n) push_req(REQ_CMD, rand_speed(), rand_speed());
            n = $urandom_range(1, 4);
            repeat (n) push_req(REQ_TICK, rand_speed(), rand_speed());
        end else begin
            // stray ticks, maybe ignored if the block has stopped
            n = $urandom_range(1, 5);
            repeat (n) push_req(REQ_TICK, rand_speed(), rand_speed());
        end
    endtask

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        int ph;
        int budget;
        int target;
        int max_ticks;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset tables: tick while stopped, saturation corners, reversals
        push_req(REQ_TICK, 100, 100);
        push_req(REQ_CMD, 32767, -32768);
        repeat (6) push_req(REQ_TICK, 0, 0);
        push_req(REQ_CMD, -32768, 32767);
        repeat (3) push_req(REQ_TICK, 0, 0);
        push_req(REQ_CMD, 256, -256);
        push_req(REQ_TICK, 0, 0);
        push_req(REQ_CMD, 0, 0);
        repeat (2) push_req(REQ_TICK, 0, 0);
        push_req(REQ_CMD, -255, 255);
        push_req(REQ_TICK, 0, 0);
        settle();

        // directed: oversized step lands on target, zero step holds, timeout of one
        write_reg(REG_STEP_LOW, 32'h0000_00FF);
        write_reg(REG_STEP_HIGH, 32'hFFFF_FFFF);
        write_reg(REG_TIMEOUT, 32'd1);
        n_settings++;
        @(negedge aclk);
        push_req(REQ_CMD, 100, -40);
        repeat (3) push_req(REQ_TICK, 0, 0);
        push_req(REQ_CMD, -1, 1);
        push_req(REQ_TICK, 0, 0);

        // random phases, each under its own register setting
        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(REG_STEP_LOW, 32'h0101_0101);
                    write_reg(REG_STEP_HIGH, 32'h0101_0101);
                    write_reg(REG_TIMEOUT, 32'd65535);
                    budget = 160; max_ticks = 40;
                end
                1: begin
                    write_reg(REG_STEP_LOW, 32'hFFFF_FFFF);
                    write_reg(REG_STEP_HIGH, 32'hFFFF_FFFF);
                    write_reg(REG_TIMEOUT, 32'd1);
                    budget = 130; max_ticks = 8;
                end
                2: begin
                    // all steps zero, speeds frozen
                    write_reg(REG_STEP_LOW, 32'h0000_0000);
                    write_reg(REG_STEP_HIGH, 32'h0000_0000);
                    write_reg(REG_TIMEOUT, 32'd50);
                    budget = 40; max_ticks = 10;
                end
                3: begin
                    write_reg(REG_STEP_LOW, $urandom());
                    write_reg(REG_STEP_HIGH, $urandom());
                    write_reg(REG_TIMEOUT, $urandom_range(1, 30));
                    budget = 160; max_ticks = 40;
                end
                4: begin
                    write_reg(REG_STEP_LOW, STEP_LOW_RST);
                    write_reg(REG_STEP_HIGH, STEP_HIGH_RST);
                    write_reg(REG_TIMEOUT, 32'(TIMEOUT_RST));
                    budget = 160; max_ticks = 70;
                end
                default: begin
                    write_reg(REG_STEP_LOW, $urandom());
                    write_reg(REG_STEP_HIGH, $urandom());
                    write_reg(REG_TIMEOUT, $urandom_range(2, 10));
                    budget = 160; max_ticks = 20;
                end
            endcase
            n_settings++;
            @(negedge aclk);
            calm = (ph == 3);
            // slow ramp phase: receiver holds off while requests keep coming
            if (ph == 0) hold_orders++;
            target = n_cmds + n_live_ticks + budget;
            while (n_cmds + n_live_ticks < target) begin
                push_burst(max_ticks);
                while (pending_reqs.size() > 8) @(negedge aclk);
            end
        end

        settle();
        repeat (END_WAIT) @(negedge aclk);
        if (duty_expect.size() != 0) begin
            errors++;
            $display("%0t: %0d predicted results never arrived", $time, duty_expect.size());
        end
        $display("covered %0d commands, %0d running ticks, %0d ignored ticks, %0d watchdog ticks",
                 n_cmds, n_live_ticks, n_dead_ticks, n_trips);
        $display("checked %0d duty results over %0d register settings, %0d errors",
                 n_results, n_settings, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dsr_pkg.sv
design/dsr_ctrl.sv
design/dsr_map.sv
design/dual_servo_ramp_with_watchdog.sv
design/dsr_checker.sv
verif/tb_top.sv
